// ===== rtl/core/vtis_pkg.sv =====
// ----------------------------------------------------------------------------
// vtis_pkg
// Shared types and constants for the vector tile issue scoreboard.
// ----------------------------------------------------------------------------
package vtis_pkg;

  localparam int unsigned NumSlots  = 9;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ProgW     = 2;
  localparam int unsigned KernelLo  = 4;
  localparam int unsigned KernelHi  = 7;
  localparam int unsigned OutSlot   = 8;

  typedef enum logic [KindW-1:0] {
    KIND_VLOAD   = 3'd0,
    KIND_MUL02   = 3'd1,
    KIND_MUL31   = 3'd2,
    KIND_MUL1221 = 3'd3,
    KIND_ADD012  = 3'd4,
    KIND_ADD321  = 3'd5,
    KIND_OACC    = 3'd6,
    KIND_VSTORE  = 3'd7
  } kind_e;

  typedef enum logic {
    MODE_CHECK = 1'b0,
    MODE_DONE  = 1'b1
  } mode_e;

  localparam logic [ProgW-1:0] ProgEmpty  = 2'd0;
  localparam logic [ProgW-1:0] ProgLoaded = 2'd1;
  localparam logic [ProgW-1:0] ProgMul    = 2'd2;
  localparam logic [ProgW-1:0] ProgAdd    = 2'd3;

endpackage

// ===== rtl/core/vector_tile_issue_scoreboard.sv =====
// ----------------------------------------------------------------------------
// vector_tile_issue_scoreboard
// Issue scoreboard: per-slot progress, per-kind and per-load-slot busy flags.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle unless in_stall_o holds it off.
// Its answer is valid on the result port once it has passed the input and
// result registers, or later while a stalled result holds the result register.
// The item is captured in the input register, then checked and applied to the
// scoreboard state as it advances into the result register. Back-to-back items
// always see the state left by the previous item, since state and result
// register update at the same edge. Done items always answer grant = 0.
module vector_tile_issue_scoreboard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [vtis_pkg::KindW-1:0] kind_i,
  input  logic [vtis_pkg::SlotW-1:0] dest_slot_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       grant_o
);

  logic                       in_vld_q;
  vtis_pkg::mode_e            mode_q;
  vtis_pkg::kind_e            kind_q;
  logic [vtis_pkg::SlotW-1:0] dest_q;
  logic                       out_vld_q;
  logic                       grant_q, grant_d;

  logic [vtis_pkg::ProgW-1:0] prog_q [vtis_pkg::NumSlots];
  logic [vtis_pkg::ProgW-1:0] prog_d [vtis_pkg::NumSlots];
  logic [7:1]                 kind_busy_q, kind_busy_d;
  logic [vtis_pkg::NumSlots-1:0] load_busy_q, load_busy_d;

  logic advance, in_acc;
  logic kernel_busy, dest_ok, dest_kernel, ok;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign kernel_busy = |load_busy_q[vtis_pkg::KernelHi:vtis_pkg::KernelLo];
  assign dest_ok     = dest_q < vtis_pkg::SlotW'(vtis_pkg::NumSlots);
  assign dest_kernel = (dest_q >= vtis_pkg::SlotW'(vtis_pkg::KernelLo)) &&
                       (dest_q <= vtis_pkg::SlotW'(vtis_pkg::KernelHi));

  always_comb begin
    ok = 1'b0;
    unique case (kind_q)
      vtis_pkg::KIND_VLOAD: begin
        if (dest_ok) begin
          ok = !load_busy_q[dest_q] && (prog_q[dest_q] == vtis_pkg::ProgEmpty) &&
               (dest_kernel ? !kind_busy_q[vtis_pkg::KIND_VSTORE] : !kernel_busy);
        end
      end
      vtis_pkg::KIND_MUL02:
        ok = (prog_q[0] == vtis_pkg::ProgLoaded) && (prog_q[2] == vtis_pkg::ProgLoaded);
      vtis_pkg::KIND_MUL31:
        ok = (prog_q[3] == vtis_pkg::ProgLoaded) && (prog_q[1] == vtis_pkg::ProgLoaded);
      vtis_pkg::KIND_MUL1221:
        ok = (prog_q[1] == vtis_pkg::ProgLoaded) && (prog_q[2] == vtis_pkg::ProgLoaded);
      vtis_pkg::KIND_ADD012:
        ok = (prog_q[0] == vtis_pkg::ProgMul) && (prog_q[1] == vtis_pkg::ProgMul) &&
             (prog_q[2] == vtis_pkg::ProgMul);
      vtis_pkg::KIND_ADD321:
        ok = (prog_q[3] == vtis_pkg::ProgMul) && (prog_q[2] == vtis_pkg::ProgMul) &&
             (prog_q[1] == vtis_pkg::ProgMul);
      vtis_pkg::KIND_OACC:
        ok = (prog_q[0] == vtis_pkg::ProgAdd) && (prog_q[3] == vtis_pkg::ProgAdd) &&
             (prog_q[vtis_pkg::OutSlot] == vtis_pkg::ProgLoaded);
      vtis_pkg::KIND_VSTORE:
        ok = (prog_q[vtis_pkg::OutSlot] == vtis_pkg::ProgMul);
      default: ok = 1'b0;
    endcase
    if (kind_q != vtis_pkg::KIND_VLOAD) begin
      ok = ok && !kind_busy_q[kind_q] && !kernel_busy;
    end
  end

  always_comb begin
    prog_d      = prog_q;
    kind_busy_d = kind_busy_q;
    load_busy_d = load_busy_q;
    grant_d     = 1'b0;
    if (mode_q == vtis_pkg::MODE_CHECK) begin
      grant_d = ok;
      if (ok) begin
        if (kind_q == vtis_pkg::KIND_VLOAD) load_busy_d[dest_q] = 1'b1;
        else kind_busy_d[kind_q] = 1'b1;
      end
    end else begin
      unique case (kind_q)
        vtis_pkg::KIND_VLOAD: begin
          if (dest_ok) begin
            load_busy_d[dest_q] = 1'b0;
            prog_d[dest_q]      = vtis_pkg::ProgLoaded;
          end
        end
        vtis_pkg::KIND_MUL02:   prog_d[0] = vtis_pkg::ProgMul;
        vtis_pkg::KIND_MUL31:   prog_d[3] = vtis_pkg::ProgMul;
        vtis_pkg::KIND_MUL1221: begin
          prog_d[1] = vtis_pkg::ProgMul;
          prog_d[2] = vtis_pkg::ProgMul;
        end
        vtis_pkg::KIND_ADD012:  prog_d[0] = vtis_pkg::ProgAdd;
        vtis_pkg::KIND_ADD321:  prog_d[3] = vtis_pkg::ProgAdd;
        vtis_pkg::KIND_OACC: begin
          for (int s = 0; s < 4; s++) prog_d[s] = vtis_pkg::ProgEmpty;
          prog_d[vtis_pkg::OutSlot] = vtis_pkg::ProgMul;
        end
        vtis_pkg::KIND_VSTORE:  prog_d[vtis_pkg::OutSlot] = vtis_pkg::ProgEmpty;
        default: ;
      endcase
      if (kind_q != vtis_pkg::KIND_VLOAD) kind_busy_d[kind_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      kind_busy_q <= '0;
      load_busy_q <= '0;
      for (int s = 0; s < vtis_pkg::NumSlots; s++) prog_q[s] <= vtis_pkg::ProgEmpty;
    end else begin
      if (in_acc) in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
      if (advance) begin
        prog_q      <= prog_d;
        kind_busy_q <= kind_busy_d;
        load_busy_q <= load_busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= vtis_pkg::mode_e'(mode_i);
      kind_q <= vtis_pkg::kind_e'(kind_i);
      dest_q <= dest_slot_i;
    end
    if (advance) grant_q <= grant_d;
  end

  assign out_valid_o = out_vld_q;
  assign grant_o     = grant_q;

endmodule

// ===== rtl/core/vtis_checker.sv =====
// ----------------------------------------------------------------------------
// vtis_checker
// Port-level assertions for the vector tile issue scoreboard.
// ----------------------------------------------------------------------------
module vtis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic grant_o
);

  logic [1:0] in_flight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else begin
      in_flight_q <= in_flight_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(grant_o))
    else $error("stalled result changed");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q != 2'd3)
    else $error("more than two transactions in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_flight_q != 2'd0)
    else $error("result without an accepted transaction");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_flight_q == 2'd2) && out_stall_i |-> in_stall_o)
    else $error("input accepted while full and stalled");

endmodule

bind vector_tile_issue_scoreboard vtis_checker u_vtis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .grant_o     (grant_o)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vector_tile_issue_scoreboard. A queue of check and
// done transactions is driven through the valid/stall input channel: a short
// directed run over blocking, ordering and out-of-range loads, then complete
// issue rounds (loads, muls, adds, oacc, vstore) with overlapping completions
// and random noise. A scoreboard copy in the bench predicts each grant
// answer. The monitor checks the answers in order. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module testbench;
  import vtis_pkg::*;

  typedef struct packed {
    mode_e               mode;
    kind_e               kind;
    logic [SlotW-1:0]    dest;
  } issue_item_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             mode_i      = 1'b0;
  logic [KindW-1:0] kind_i      = '0;
  logic [SlotW-1:0] dest_slot_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             grant_o;

  vector_tile_issue_scoreboard uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .kind_i      (kind_i),
    .dest_slot_i (dest_slot_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grant_o     (grant_o)
  );

  issue_item_t      pending_items_q[$];
  bit               issue_answers_q[$];
  issue_item_t      cur_item;
  bit               want_issue;
  int               accepted_cnt = 0;
  int               result_cnt   = 0;
  int               error_count  = 0;

  // bench copy of the scoreboard
  logic [ProgW-1:0] progress_r [NumSlots];
  bit               kind_busy_r [8];
  bit               load_busy_r [NumSlots];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic bit idle_roll();
    return !(accepted_cnt >= 600 && accepted_cnt < 900) && $urandom_range(0, 99) < 32;
  endfunction

  function automatic bit predict_issue(input issue_item_t it);
    bit ok;
    bit kern_busy;
    ok = 1'b0;
    kern_busy = 1'b0;
    for (int s = KernelLo; s <= KernelHi; s++) kern_busy |= load_busy_r[s];
    if (it.mode == MODE_CHECK) begin
      if (it.kind == KIND_VLOAD) begin
        if (it.dest < NumSlots && !load_busy_r[it.dest]) begin
          if (it.dest >= KernelLo && it.dest <= KernelHi) begin
            ok = !kind_busy_r[KIND_VSTORE] && progress_r[it.dest] == ProgEmpty;
          end else begin
            ok = !kern_busy && progress_r[it.dest] == ProgEmpty;
          end
        end
        if (ok) load_busy_r[it.dest] = 1'b1;
      end else begin
        if (!kind_busy_r[it.kind] && !kern_busy) begin
          case (it.kind)
            KIND_MUL02:   ok = progress_r[0] == ProgLoaded && progress_r[2] == ProgLoaded;
            KIND_MUL31:   ok = progress_r[3] == ProgLoaded && progress_r[1] == ProgLoaded;
            KIND_MUL1221: ok = progress_r[1] == ProgLoaded && progress_r[2] == ProgLoaded;
            KIND_ADD012:  ok = progress_r[0] == ProgMul && progress_r[1] == ProgMul &&
                               progress_r[2] == ProgMul;
            KIND_ADD321:  ok = progress_r[3] == ProgMul && progress_r[2] == ProgMul &&
                               progress_r[1] == ProgMul;
            KIND_OACC:    ok = progress_r[0] == ProgAdd && progress_r[3] == ProgAdd &&
                               progress_r[OutSlot] == ProgLoaded;
            default:      ok = progress_r[OutSlot] == ProgMul;
          endcase
        end
        if (ok) kind_busy_r[it.kind] = 1'b1;
      end
    end else begin
      case (it.kind)
        KIND_VLOAD: begin
          if (it.dest < NumSlots) begin
            load_busy_r[it.dest] = 1'b0;
            progress_r[it.dest]  = ProgLoaded;
          end
        end
        KIND_MUL02:   progress_r[0] = ProgMul;
        KIND_MUL31:   progress_r[3] = ProgMul;
        KIND_MUL1221: begin
          progress_r[1] = ProgMul;
          progress_r[2] = ProgMul;
        end
        KIND_ADD012:  progress_r[0] = ProgAdd;
        KIND_ADD321:  progress_r[3] = ProgAdd;
        KIND_OACC: begin
          for (int s = 0; s < 4; s++) progress_r[s] = ProgEmpty;
          progress_r[OutSlot] = ProgMul;
        end
        default:      progress_r[OutSlot] = ProgEmpty;
      endcase
      if (it.kind != KIND_VLOAD) kind_busy_r[it.kind] = 1'b0;
    end
    return ok;
  endfunction

  task automatic push_item(input mode_e m, input kind_e k, input logic [SlotW-1:0] d);
    issue_item_t it;
    it.mode = m;
    it.kind = k;
    it.dest = d;
    pending_items_q.push_back(it);
  endtask

  task automatic push_noise();
    push_item(mode_e'($urandom_range(0, 1)), kind_e'($urandom_range(0, 7)),
              SlotW'($urandom_range(0, 15)));
  endtask

  // one pass through the instruction flow, completions sometimes deferred
  task automatic add_round();
    int          loads[5];
    int          j;
    int          tmp;
    int          roll;
    issue_item_t ops[$];
    issue_item_t held[$];
    issue_item_t op;
    loads = '{0, 1, 2, 3, OutSlot};
    for (int i = 4; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = loads[i];
      loads[i] = loads[j];
      loads[j] = tmp;
    end
    op.mode = MODE_CHECK;
    if ($urandom_range(0, 3) == 0) begin
      op.kind = KIND_VLOAD;
      op.dest = SlotW'($urandom_range(KernelLo, KernelHi));
      ops.push_back(op);
    end
    for (int i = 0; i < 5; i++) begin
      op.kind = KIND_VLOAD;
      op.dest = SlotW'(loads[i]);
      ops.push_back(op);
    end
    op.dest = SlotW'($urandom_range(0, 15));
    if ($urandom_range(0, 1)) begin
      op.kind = KIND_MUL02;  ops.push_back(op);
      op.kind = KIND_MUL31;  ops.push_back(op);
    end else begin
      op.kind = KIND_MUL31;  ops.push_back(op);
      op.kind = KIND_MUL02;  ops.push_back(op);
    end
    op.kind = KIND_MUL1221; ops.push_back(op);
    if ($urandom_range(0, 1)) begin
      op.kind = KIND_ADD012; ops.push_back(op);
      op.kind = KIND_ADD321; ops.push_back(op);
    end else begin
      op.kind = KIND_ADD321; ops.push_back(op);
      op.kind = KIND_ADD012; ops.push_back(op);
    end
    op.kind = KIND_OACC;   ops.push_back(op);
    op.kind = KIND_VSTORE; ops.push_back(op);
    foreach (ops[i]) begin
      op = ops[i];
      if (op.kind != KIND_VLOAD) op.dest = SlotW'($urandom_range(0, 15));
      push_item(MODE_CHECK, op.kind, op.dest);
      while (held.size() > 0) begin
        op = held.pop_front();
        push_item(MODE_DONE, op.kind, op.dest);
      end
      op = ops[i];
      roll = $urandom_range(0, 99);
      if (roll < 15) push_noise();
      else if (roll < 25) push_item(MODE_CHECK, op.kind, op.dest);
      if ($urandom_range(0, 99) < 20) held.push_back(op);
      else push_item(MODE_DONE, op.kind, op.dest);
    end
    while (held.size() > 0) begin
      op = held.pop_front();
      push_item(MODE_DONE, op.kind, op.dest);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      mode_i      <= MODE_CHECK;
      kind_i      <= KIND_VLOAD;
      dest_slot_i <= '0;
      for (int s = 0; s < NumSlots; s++) begin
        progress_r[s]  = ProgEmpty;
        load_busy_r[s] = 1'b0;
      end
      for (int k = 0; k < 8; k++) kind_busy_r[k] = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        issue_answers_q.push_back(predict_issue(cur_item));
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items_q.size() > 0 && !idle_roll()) begin
          cur_item = pending_items_q.pop_front();
          mode_i      <= cur_item.mode;
          kind_i      <= cur_item.kind;
          dest_slot_i <= cur_item.dest;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i  <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (issue_answers_q.size() == 0) begin
          report_mismatch("result transaction with no outstanding request");
        end else begin
          want_issue = issue_answers_q.pop_front();
          if (grant_o !== want_issue)
            report_mismatch($sformatf("result %0d: grant %b, expected %b",
                                      result_cnt, grant_o, want_issue));
        end
        result_cnt++;
      end
      out_stall_i <= idle_roll();
    end
  end

  initial begin
    // kernel load ordering and busy checks
    push_item(MODE_CHECK, KIND_VLOAD,   4'd4);
    push_item(MODE_CHECK, KIND_MUL02,   4'd15);
    push_item(MODE_CHECK, KIND_VLOAD,   4'd0);
    push_item(MODE_CHECK, KIND_VSTORE,  4'd0);
    push_item(MODE_CHECK, KIND_VLOAD,   4'd5);
    push_item(MODE_DONE,  KIND_VLOAD,   4'd4);
    push_item(MODE_DONE,  KIND_VLOAD,   4'd5);
    // out-of-range load slot
    push_item(MODE_CHECK, KIND_VLOAD,   4'd9);
    push_item(MODE_CHECK, KIND_VLOAD,   4'd15);
    push_item(MODE_DONE,  KIND_VLOAD,   4'd15);
    push_item(MODE_CHECK, KIND_VLOAD,   SlotW'(OutSlot));
    push_item(MODE_DONE,  KIND_VLOAD,   SlotW'(OutSlot));
    push_item(MODE_CHECK, KIND_VLOAD,   SlotW'(OutSlot));
    push_item(MODE_CHECK, KIND_OACC,    4'd15);
    // completion without issue
    push_item(MODE_DONE,  KIND_OACC,    4'd0);
    push_item(MODE_CHECK, KIND_VSTORE,  4'd15);
    push_item(MODE_CHECK, KIND_VLOAD,   4'd6);
    push_item(MODE_CHECK, KIND_VSTORE,  4'd7);
    push_item(MODE_DONE,  KIND_VSTORE,  4'd15);
    push_item(MODE_CHECK, KIND_VLOAD,   4'd6);
    push_item(MODE_DONE,  KIND_VLOAD,   4'd6);
    push_item(MODE_CHECK, KIND_MUL31,   4'd8);
    push_item(MODE_CHECK, KIND_MUL1221, 4'd1);
    push_item(MODE_CHECK, KIND_ADD012,  4'd2);
    push_item(MODE_CHECK, KIND_ADD321,  4'd12);
    push_item(MODE_DONE,  KIND_ADD321,  4'd15);
    while (pending_items_q.size() < 1626) add_round();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (issue_answers_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS vector_tile_issue_scoreboard");
    end else begin
      $display("FAIL vector_tile_issue_scoreboard");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL vector_tile_issue_scoreboard");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vtis_pkg.sv
rtl/core/vector_tile_issue_scoreboard.sv
rtl/core/vtis_checker.sv
tb/sv/testbench.sv
